### design/iq4xs_pkg.sv
package iq4xs_pkg;

  // Register map: two 64-bit codebook words at byte offsets 0 and 8
  localparam int unsigned PADDR_W   = 4;
  localparam int unsigned PDATA_W   = 64;
  localparam logic        REG_CB_LO = 1'b0;
  localparam logic        REG_CB_HI = 1'b1;

  // Item kinds
  localparam logic MODE_HEADER = 1'b0;
  localparam logic MODE_DATA   = 1'b1;

  // Super-block geometry: 128 bytes, 8 sub-blocks of 16 bytes
  localparam int unsigned POS_W      = 7;
  localparam int unsigned SUB_IDX_W  = 3;
  localparam int unsigned SUB_LSB    = 4;
  localparam int unsigned SCALE_OFFSET = 32;

  // Datapath widths
  localparam int unsigned ACT_W     = 16;
  localparam int unsigned CB_W      = 8;
  localparam int unsigned PROD_W    = ACT_W + CB_W;       // lane product
  localparam int unsigned INNER_W   = PROD_W + 1;         // sum of two lanes
  localparam int unsigned SUBOFF_W  = 7;                  // sub_scale - 32
  localparam int unsigned SCALE_W   = ACT_W + SUBOFF_W;   // d * (sub_scale - 32)
  localparam int unsigned CONTRIB_W = INNER_W + SCALE_W;  // one item's term
  localparam int unsigned ACC_W     = 64;

  // Control carried down the pipeline with each data beat
  typedef struct packed {
    logic valid;
    logic last;
  } pipe_ctl_t;

  // Signed codebook byte for a 4-bit index
  function automatic logic signed [CB_W-1:0] cb_entry(
    input logic [63:0] lo_word,
    input logic [63:0] hi_word,
    input logic [3:0]  idx
  );
    logic [63:0] word;
    word = idx[3] ? hi_word : lo_word;
    return $signed(word[idx[2:0]*CB_W +: CB_W]);
  endfunction

endpackage

### design/iq4xs_lane.sv
module iq4xs_lane (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic [63:0]                          cb_lo,
  input  logic [63:0]                          cb_hi,
  input  logic [3:0]                           idx,
  input  logic signed [iq4xs_pkg::ACT_W-1:0]   act,
  output logic signed [iq4xs_pkg::PROD_W-1:0]  prod
);
  import iq4xs_pkg::*;

  logic signed [CB_W-1:0] weight;

  // Codebook lookup for this nibble
  assign weight = cb_entry(cb_lo, cb_hi, idx);

  // Registered weight * activation
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= PROD_W'(weight * act);
    end
  end

endmodule

### design/iq4xs_merge.sv
module iq4xs_merge (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  adv,
  input  iq4xs_pkg::pipe_ctl_t                  s1_ctl,
  input  logic signed [iq4xs_pkg::PROD_W-1:0]   prod_lo,
  input  logic signed [iq4xs_pkg::PROD_W-1:0]   prod_hi,
  input  logic signed [iq4xs_pkg::SCALE_W-1:0]  s1_scale,
  input  logic                                  out_stall,
  output logic                                  out_valid,
  output logic signed [iq4xs_pkg::ACC_W-1:0]    row_sum,
  output logic                                  overflow
);
  import iq4xs_pkg::*;

  pipe_ctl_t                    s2_ctl;
  logic signed [CONTRIB_W-1:0]  contrib;
  logic signed [INNER_W-1:0]    inner;
  logic signed [ACC_W-1:0]      acc;
  logic                         sat_flag;
  logic signed [ACC_W:0]        wide_sum;
  logic signed [ACC_W-1:0]      sat_sum;
  logic                         sat_hit;

  // Merge the two lanes, then apply the block and sub-block scale
  assign inner = INNER_W'(prod_lo) + INNER_W'(prod_hi);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_ctl <= '0;
    end else if (adv) begin
      s2_ctl <= s1_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      contrib <= CONTRIB_W'(s1_scale * inner);
    end
  end

  // Saturating accumulate
  assign wide_sum = {acc[ACC_W-1], acc} + (ACC_W+1)'(contrib);
  assign sat_hit  = wide_sum[ACC_W] != wide_sum[ACC_W-1];
  always_comb begin
    if (!sat_hit) begin
      sat_sum = wide_sum[ACC_W-1:0];
    end else if (wide_sum[ACC_W]) begin
      sat_sum = {1'b1, {(ACC_W-1){1'b0}}};
    end else begin
      sat_sum = {1'b0, {(ACC_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc      <= '0;
      sat_flag <= 1'b0;
    end else if (adv && s2_ctl.valid) begin
      if (s2_ctl.last) begin
        acc      <= '0;
        sat_flag <= 1'b0;
      end else begin
        acc      <= sat_sum;
        sat_flag <= sat_flag | sat_hit;
      end
    end
  end

  // Output register; holds while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s2_ctl.valid && s2_ctl.last;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s2_ctl.valid && s2_ctl.last) begin
      row_sum  <= sat_sum;
      overflow <= sat_flag | sat_hit;
    end
  end

  // Row end clears the accumulator
  a_row_clear: assert property (@(posedge clk) disable iff (rst)
    adv && s2_ctl.valid && s2_ctl.last |=> acc == '0 && !sat_flag)
    else $error("accumulator not cleared after row end");

  // A result appears only from a row-ending beat
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(adv && s2_ctl.valid && s2_ctl.last))
    else $error("result without row-ending beat");

  // Pipeline frozen while a result is held
  a_freeze: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> !adv)
    else $error("pipeline advanced over a held result");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid && acc == '0)
    else $error("reset did not clear output and accumulator");

endmodule

### design/iq4xs_dequant_dot_product.sv
// IQ4_XS dequantizing dot-product accumulator.
// Input channel (in_valid / in_stall): one beat per item. A header beat
// (mode 0) loads the block scale and the packed sub-scales and restarts the
// byte position; a data beat (mode 1) carries one weight byte and the two
// activations it pairs with. Two lanes look up the codebook for the low and
// high nibble and multiply by their activation; a merge stage sums them,
// scales by d * (sub_scale - 32) and adds into a saturating 64-bit
// accumulator.
// Output channel (out_valid / out_stall): one beat per row, on the data beat
// marked last_in_row, giving row_sum and the overflow flag.
// Throughput: one item per cycle, except while a held result is stalled. The
// result of a row passes through the lane product register (at the
// accepting edge), the scaled-term register and the accumulate/output
// register, where out_valid rises.
// While a result is held and out_stall is high, the whole pipeline freezes
// and in_stall is raised.
// Reset (rst, synchronous) clears the codebook, the held scales, the byte
// position, the accumulator and out_valid.
// Codebook words are written through the APB port at offsets 0 and 8; the user
// must write them only while no row is in flight, as the block does not enforce it.
module iq4xs_dequant_dot_product (
  input  logic                                  clk,
  input  logic                                  rst,
  // configuration
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [iq4xs_pkg::PADDR_W-1:0]         paddr,
  input  logic [iq4xs_pkg::PDATA_W-1:0]         pwdata,
  output logic [iq4xs_pkg::PDATA_W-1:0]         prdata,
  output logic                                  pready,
  // input channel
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  mode,
  input  logic signed [15:0]                    block_scale,
  input  logic [15:0]                           scale_high_bits,
  input  logic [31:0]                           scale_low_bits,
  input  logic [7:0]                            weight_byte,
  input  logic signed [15:0]                    act_first,
  input  logic signed [15:0]                    act_second,
  input  logic                                  last_in_row,
  // output channel
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [iq4xs_pkg::ACC_W-1:0]    row_sum,
  output logic                                  overflow
);
  import iq4xs_pkg::*;

  logic [PDATA_W-1:0]          cb_lo;
  logic [PDATA_W-1:0]          cb_hi;
  logic signed [ACT_W-1:0]     held_block_scale;
  logic [15:0]                 held_scale_high;
  logic [31:0]                 held_scale_low;
  logic [POS_W-1:0]            byte_position;
  logic                        adv;
  logic                        accept;
  logic                        data_beat;
  logic [SUB_IDX_W-1:0]        sub_idx;
  logic [5:0]                  sub_scale;
  logic signed [SUBOFF_W-1:0]  sub_off;
  pipe_ctl_t                   s1_ctl;
  logic signed [SCALE_W-1:0]   s1_scale;
  logic signed [PROD_W-1:0]    prod_lo;
  logic signed [PROD_W-1:0]    prod_hi;

  // APB register file
  assign pready = 1'b1;
  assign prdata = (paddr[3] == REG_CB_HI) ? cb_hi : cb_lo;

  always_ff @(posedge clk) begin
    if (rst) begin
      cb_lo <= '0;
      cb_hi <= '0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[3])
        REG_CB_LO: cb_lo <= pwdata;
        REG_CB_HI: cb_hi <= pwdata;
        default:   ;
      endcase
    end
  end

  // Handshake: whole pipeline moves unless a held result is stalled
  assign adv       = !(out_valid && out_stall);
  assign in_stall  = !adv;
  assign accept    = in_valid && adv;
  assign data_beat = accept && (mode == MODE_DATA);

  // Header state and byte position
  always_ff @(posedge clk) begin
    if (rst) begin
      held_block_scale <= '0;
      held_scale_high  <= '0;
      held_scale_low   <= '0;
      byte_position    <= '0;
    end else if (accept) begin
      if (mode == MODE_HEADER) begin
        held_block_scale <= block_scale;
        held_scale_high  <= scale_high_bits;
        held_scale_low   <= scale_low_bits;
        byte_position    <= '0;
      end else begin
        byte_position    <= byte_position + 1'b1;
      end
    end
  end

  // Sub-block scale for the current byte, offset and times d
  assign sub_idx   = byte_position[POS_W-1:SUB_LSB];
  assign sub_scale = {held_scale_high[sub_idx*2 +: 2], held_scale_low[sub_idx*4 +: 4]};
  assign sub_off   = $signed({1'b0, sub_scale}) - SUBOFF_W'(SCALE_OFFSET);

  always_ff @(posedge clk) begin
    if (data_beat) begin
      s1_scale <= SCALE_W'(held_block_scale * sub_off);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctl <= '0;
    end else if (adv) begin
      s1_ctl.valid <= data_beat;
      s1_ctl.last  <= last_in_row;
    end
  end

  // Nibble lanes
  iq4xs_lane u_lane_lo (
    .clk   (clk),
    .en    (data_beat),
    .cb_lo (cb_lo),
    .cb_hi (cb_hi),
    .idx   (weight_byte[3:0]),
    .act   (act_first),
    .prod  (prod_lo)
  );

  iq4xs_lane u_lane_hi (
    .clk   (clk),
    .en    (data_beat),
    .cb_lo (cb_lo),
    .cb_hi (cb_hi),
    .idx   (weight_byte[7:4]),
    .act   (act_second),
    .prod  (prod_hi)
  );

  // Merge, scale and accumulate
  iq4xs_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .s1_ctl    (s1_ctl),
    .prod_lo   (prod_lo),
    .prod_hi   (prod_hi),
    .s1_scale  (s1_scale),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .row_sum   (row_sum),
    .overflow  (overflow)
  );

endmodule
